>>> hw/rtl/hpm_pkg.sv
// Package for the homography point mapper: widths, register indexes, stage types.
// No dependencies.
package hpm_pkg;
    localparam int COEF_W  = 64;
    localparam int OUT_W   = 32;
    localparam int SUM_W   = 84;             // 84 bits: room for exact sums of two 77-bit products and an offset
    localparam int NUM_W   = SUM_W + 16;     // dividend magnitude after Q16 shift
    localparam int NREG    = 8;
    localparam int IDX_W   = 4;
    localparam logic [OUT_W-1:0] INVALID_COORD = 32'hFFFF_0000;

    typedef enum logic [IDX_W-1:0] {
        REG_R0X = 4'd0, REG_R0Y = 4'd1, REG_R0O = 4'd2,
        REG_R1X = 4'd3, REG_R1Y = 4'd4, REG_R1O = 4'd5,
        REG_R2X = 4'd6, REG_R2Y = 4'd7
    } t_reg_idx;

    // Per-lane divider state handed from cell to cell.
    typedef struct packed {
        logic [NUM_W-1:0] num;   // remaining dividend bits, MSB first
        logic [SUM_W:0]   rem;   // partial remainder
        logic [NUM_W-1:0] quo;   // quotient bits so far
    } t_lane;

    // Item-level control carried alongside the lanes.
    typedef struct packed {
        logic             vld;
        logic             zero_den;
        logic             neg_u;
        logic             neg_v;
        logic [SUM_W-1:0] den;   // denominator magnitude
    } t_ctl;
endpackage

>>> hw/rtl/hpm_div_cell.sv
// One restoring-division cell: retires one quotient bit for both lanes.
// Depends on hpm_pkg.
module hpm_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  hpm_pkg::t_ctl  i_ctl,
    input  hpm_pkg::t_lane i_u,
    input  hpm_pkg::t_lane i_v,
    output hpm_pkg::t_ctl  o_ctl,
    output hpm_pkg::t_lane o_u,
    output hpm_pkg::t_lane o_v
);
    hpm_pkg::t_ctl  r_ctl;
    hpm_pkg::t_lane r_u, r_v, n_u, n_v;

    function automatic hpm_pkg::t_lane step(hpm_pkg::t_lane a, logic [hpm_pkg::SUM_W-1:0] d);
        hpm_pkg::t_lane      b;
        logic [hpm_pkg::SUM_W:0] sh;
        logic [hpm_pkg::SUM_W:0] df;
        sh = {a.rem[hpm_pkg::SUM_W-1:0], a.num[hpm_pkg::NUM_W-1]};
        df = sh - {1'b0, d};
        b.num = {a.num[hpm_pkg::NUM_W-2:0], 1'b0};
        if (!df[hpm_pkg::SUM_W]) begin
            b.rem = df;
            b.quo = {a.quo[hpm_pkg::NUM_W-2:0], 1'b1};
        end else begin
            b.rem = sh;
            b.quo = {a.quo[hpm_pkg::NUM_W-2:0], 1'b0};
        end
        return b;
    endfunction

    always_comb begin
        n_u = step(i_u, i_ctl.den);
        n_v = step(i_v, i_ctl.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_ctl.vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.zero_den <= i_ctl.zero_den;
            r_ctl.neg_u    <= i_ctl.neg_u;
            r_ctl.neg_v    <= i_ctl.neg_v;
            r_ctl.den      <= i_ctl.den;
            r_u            <= n_u;
            r_v            <= n_v;
        end
    end

    assign o_ctl = r_ctl;
    assign o_u   = r_u;
    assign o_v   = r_v;
endmodule

>>> hw/rtl/hpm_front.sv
// Front end: products, exact affine sums, signs and magnitudes over three stages.
// Depends on hpm_pkg.
module hpm_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [COORD_BITS-1:0]  i_x,
    input  logic [COORD_BITS-1:0]  i_y,
    input  logic [hpm_pkg::NREG-1:0][hpm_pkg::COEF_W-1:0] i_coef,
    output hpm_pkg::t_ctl          o_ctl,
    output hpm_pkg::t_lane         o_u,
    output hpm_pkg::t_lane         o_v
);
    localparam int PW = hpm_pkg::COEF_W + COORD_BITS + 1;
    localparam int SW = hpm_pkg::SUM_W;

    // stage 1: six coefficient x coordinate products (64 x 13 signed)
    logic            r_v1;
    logic signed [PW-1:0] r_p [6];
    logic signed [hpm_pkg::COEF_W-1:0] r_o0, r_o1;
    // stage 2: sums
    logic            r_v2;
    logic signed [SW-1:0] r_su, r_sv, r_ss;
    // stage 3: magnitudes
    hpm_pkg::t_ctl   r_ctl;
    logic [SW-1:0]   r_mu, r_mv;

    logic signed [COORD_BITS:0] sx, sy;
    logic signed [SW-1:0] n_su, n_sv, n_ss;
    assign sx = $signed({1'b0, i_x});
    assign sy = $signed({1'b0, i_y});

    always_comb begin
        n_su = SW'(r_p[0]) + SW'(r_p[1]) + SW'(r_o0);
        n_sv = SW'(r_p[2]) + SW'(r_p[3]) + SW'(r_o1);
        n_ss = SW'(r_p[4]) + SW'(r_p[5]) + SW'(65'sh1_0000_0000);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_v1      <= i_vld;
            r_v2      <= r_v1;
            r_ctl.vld <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= $signed(i_coef[hpm_pkg::REG_R0X]) * sx;
            r_p[1] <= $signed(i_coef[hpm_pkg::REG_R0Y]) * sy;
            r_p[2] <= $signed(i_coef[hpm_pkg::REG_R1X]) * sx;
            r_p[3] <= $signed(i_coef[hpm_pkg::REG_R1Y]) * sy;
            r_p[4] <= $signed(i_coef[hpm_pkg::REG_R2X]) * sx;
            r_p[5] <= $signed(i_coef[hpm_pkg::REG_R2Y]) * sy;
            r_o0   <= $signed(i_coef[hpm_pkg::REG_R0O]);
            r_o1   <= $signed(i_coef[hpm_pkg::REG_R1O]);
            r_su   <= n_su;
            r_sv   <= n_sv;
            r_ss   <= n_ss;
            r_ctl.zero_den <= (r_ss == '0);
            r_ctl.neg_u    <= r_su[SW-1] ^ r_ss[SW-1];
            r_ctl.neg_v    <= r_sv[SW-1] ^ r_ss[SW-1];
            r_ctl.den      <= r_ss[SW-1] ? -r_ss : r_ss;
            r_mu           <= r_su[SW-1] ? -r_su : r_su;
            r_mv           <= r_sv[SW-1] ? -r_sv : r_sv;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_u.num = {r_mu, 16'd0};
    assign o_u.rem = '0;
    assign o_u.quo = '0;
    assign o_v.num = {r_mv, 16'd0};
    assign o_v.rem = '0;
    assign o_v.quo = '0;
endmodule

>>> hw/rtl/hpm_round.sv
// Back end: round to nearest, saturate, apply sign, invalid substitution.
// Depends on hpm_pkg.
module hpm_round (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  hpm_pkg::t_ctl  i_ctl,
    input  hpm_pkg::t_lane i_u,
    input  hpm_pkg::t_lane i_v,
    output logic           o_vld,
    output logic [hpm_pkg::OUT_W-1:0] o_x,
    output logic [hpm_pkg::OUT_W-1:0] o_y,
    output logic           o_ok,
    output logic           o_sat
);
    logic r_vld, r_ok, r_sat;
    logic [hpm_pkg::OUT_W-1:0] r_x, r_y;
    logic [hpm_pkg::OUT_W-1:0] n_x, n_y;
    logic sat_x, sat_y;

    function automatic logic [hpm_pkg::OUT_W:0] fin(hpm_pkg::t_lane a,
            logic [hpm_pkg::SUM_W-1:0] d, logic neg);
        logic [hpm_pkg::NUM_W:0]   q;
        logic [hpm_pkg::SUM_W+1:0] r2;
        logic [hpm_pkg::OUT_W-1:0] lim;
        logic [hpm_pkg::OUT_W-1:0] mag;
        logic                      s;
        r2  = {a.rem, 1'b0};
        q   = {1'b0, a.quo} + {{hpm_pkg::NUM_W{1'b0}}, (r2 >= {2'b0, d})};
        lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        s   = (q > {{(hpm_pkg::NUM_W-hpm_pkg::OUT_W+1){1'b0}}, lim});
        mag = s ? lim : q[hpm_pkg::OUT_W-1:0];
        return {s, neg ? -mag : mag};
    endfunction

    always_comb begin
        {sat_x, n_x} = fin(i_u, i_ctl.den, i_ctl.neg_u);
        {sat_y, n_y} = fin(i_v, i_ctl.den, i_ctl.neg_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok  <= !i_ctl.zero_den;
            r_sat <= !i_ctl.zero_den && (sat_x || sat_y);
            r_x   <= i_ctl.zero_den ? hpm_pkg::INVALID_COORD : n_x;
            r_y   <= i_ctl.zero_den ? hpm_pkg::INVALID_COORD : n_y;
        end
    end

    assign o_vld = r_vld;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_ok  = r_ok;
    assign o_sat = r_sat;
endmodule

>>> hw/rtl/homography_point_mapper.sv
// Top level of the homography point mapper: config registers, front end,
// division cell chain, rounding stage. Depends on hpm_pkg and all hpm_* modules.
//
// Usage:
//  - Input channel (i_valid/o_ready) carries one destination pixel per transaction.
//  - Output channel (o_valid/i_ready) returns src_x, src_y (Q15.16), valid_res, saturated.
//  - Config channel (i_cfg_valid/o_cfg_ready) writes one Q31.32 coefficient by index
//    0..7; other indexes are dropped. Write only while the pipeline is empty.
//  - Throughput: one transaction per clock while the skid register is empty. The
//    whole datapath is one pipeline: three front-end stages (products, sums,
//    magnitudes), one restoring-division cell per quotient bit (NUM_W = 100 cells,
//    each retiring one bit for u and v), and one rounding/saturation stage.
//  - Stall: when the receiver holds off a waiting result, the pipeline advances once
//    more and parks that result in a skid register; from the next cycle o_ready is
//    low and every stage holds until the skid register is taken. o_ready comes from
//    a register only, never from i_ready. Nothing is lost; rate is set by the receiver.
//  - Reset: all stage valids and the skid register's valid clear, coefficients
//    return to the identity matrix.
//  - Zero denominator yields (-1.0, -1.0) with valid_res low and saturated low.
module homography_point_mapper #(
    parameter int COORD_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_BITS-1:0]  i_dst_x,
    input  logic [COORD_BITS-1:0]  i_dst_y,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [31:0]            o_src_x,
    output logic [31:0]            o_src_y,
    output logic                   o_valid_res,
    output logic                   o_saturated,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [hpm_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [hpm_pkg::COEF_W-1:0] i_cfg_data
);
    localparam int NC = hpm_pkg::NUM_W;
    // Identity matrix: row0_x_gain and row1_y_gain are 1.0, all else zero.
    localparam logic [hpm_pkg::NREG-1:0][hpm_pkg::COEF_W-1:0] COEF_RESET = {
        64'h0, 64'h0, 64'h0, 64'h1_0000_0000,
        64'h0, 64'h0, 64'h0, 64'h1_0000_0000
    };

    logic [hpm_pkg::NREG-1:0][hpm_pkg::COEF_W-1:0] r_coef;
    logic en;

    // Pipeline output and the skid register behind it.
    logic        p_vld, p_ok, p_sat;
    logic [31:0] p_x, p_y;
    logic        r_skid_vld, r_skid_ok, r_skid_sat;
    logic [31:0] r_skid_x, r_skid_y;

    // Advance while the skid register is empty.
    assign en          = !r_skid_vld;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RESET;
        end else if (i_cfg_valid && i_cfg_index < hpm_pkg::IDX_W'(hpm_pkg::NREG)) begin
            r_coef[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    hpm_pkg::t_ctl  c_ctl [NC+1];
    hpm_pkg::t_lane c_u   [NC+1];
    hpm_pkg::t_lane c_v   [NC+1];

    hpm_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(i_valid),
        .i_x(i_dst_x), .i_y(i_dst_y),
        .i_coef(r_coef),
        .o_ctl(c_ctl[0]), .o_u(c_u[0]), .o_v(c_v[0])
    );

    // Chain of division cells: each hands its partial remainder to the next.
    for (genvar g = 0; g < NC; g++) begin : g_cell
        hpm_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(c_ctl[g]), .i_u(c_u[g]), .i_v(c_v[g]),
            .o_ctl(c_ctl[g+1]), .o_u(c_u[g+1]), .o_v(c_v[g+1])
        );
    end

    hpm_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_ctl(c_ctl[NC]), .i_u(c_u[NC]), .i_v(c_v[NC]),
        .o_vld(p_vld), .o_x(p_x), .o_y(p_y),
        .o_ok(p_ok), .o_sat(p_sat)
    );

    // Park a held-off result so the pipeline can take one more step; drop it once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (p_vld && !i_ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_x   <= p_x;
            r_skid_y   <= p_y;
            r_skid_ok  <= p_ok;
            r_skid_sat <= p_sat;
        end
    end

    assign o_valid     = r_skid_vld || p_vld;
    assign o_src_x     = r_skid_vld ? r_skid_x   : p_x;
    assign o_src_y     = r_skid_vld ? r_skid_y   : p_y;
    assign o_valid_res = r_skid_vld ? r_skid_ok  : p_ok;
    assign o_saturated = r_skid_vld ? r_skid_sat : p_sat;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_src_x) && $stable(o_src_y))
        else $error("output changed during stall");
    a_ready_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input blocked with no result waiting");
    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> !o_saturated && o_src_x == hpm_pkg::INVALID_COORD)
        else $error("invalid result not cleaned");
endmodule

>>> tb/sv/testbench.sv
// Self-checking bench for homography_point_mapper: directed table, then random matrices.
// Depends on hpm_pkg and the homography_point_mapper RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [hpm_pkg::IDX_W-1:0] IDX_UNUSED = 4'd9;   // beyond the register file
    localparam logic [63:0] Q_ONE    = 64'h0000_0001_0000_0000;
    localparam logic [63:0] Q_M_ONE  = 64'hFFFF_FFFF_0000_0000;
    localparam logic [63:0] Q_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN    = 64'h8000_0000_0000_0000;
    localparam int SETTLE = 110;          // pipeline latency plus margin
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 9;
    localparam int PHASE_ITEMS = 200;

    typedef struct {
        logic [31:0] sx;
        logic [31:0] sy;
        logic        vr;
        logic        sat;
    } t_point;

    typedef enum logic { ROW_CFG, ROW_POINT } t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [hpm_pkg::IDX_W-1:0] idx;
        logic [63:0]               data;
        logic [11:0]               x;
        logic [11:0]               y;
        bit                        typed;   // expectation written in the table
        t_point                    want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [11:0] i_dst_x = '0;
    logic [11:0] i_dst_y = '0;
    logic i_ready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [hpm_pkg::IDX_W-1:0] i_cfg_index = '0;
    logic [hpm_pkg::COEF_W-1:0] i_cfg_data = '0;
    logic o_ready, o_valid, o_valid_res, o_saturated, o_cfg_ready;
    logic [31:0] o_src_x, o_src_y;

    homography_point_mapper dut (.*);

    // Shadow copy of the coefficient registers.
    logic [63:0] gain [hpm_pkg::NREG];
    t_point pending_points[$];
    t_row   script[$];
    int     errors = 0;
    int     cycles = 0;
    bit     calm = 1'b0;     // no idling on either side
    int     stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Exact ratio num/den in Q15.16, rounded half away from zero, clipped.
    function automatic logic [31:0] ratio_q16(logic signed [127:0] num,
                                              logic signed [127:0] den,
                                              ref logic sat);
        logic [127:0] n, d, q, r, lim;
        logic neg;
        neg = num[127] ^ den[127];
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        n = n << 16;
        q = n / d;
        r = n % d;
        if ((r << 1) >= d) q = q + 1;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) begin
            sat = 1'b1;
            q = lim;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic logic signed [127:0] widen(logic [63:0] c);
        return {{64{c[63]}}, c};
    endfunction

    // Project one pixel through the current matrix.
    function automatic t_point project_point(logic [11:0] x, logic [11:0] y);
        logic signed [127:0] xs, ys, u, v, s;
        t_point p;
        logic sat;
        xs = {116'b0, x};
        ys = {116'b0, y};
        u = widen(gain[hpm_pkg::REG_R0X]) * xs + widen(gain[hpm_pkg::REG_R0Y]) * ys
            + widen(gain[hpm_pkg::REG_R0O]);
        v = widen(gain[hpm_pkg::REG_R1X]) * xs + widen(gain[hpm_pkg::REG_R1Y]) * ys
            + widen(gain[hpm_pkg::REG_R1O]);
        s = widen(gain[hpm_pkg::REG_R2X]) * xs + widen(gain[hpm_pkg::REG_R2Y]) * ys
            + widen(Q_ONE);
        sat = 1'b0;
        if (s == 0) begin
            p = '{hpm_pkg::INVALID_COORD, hpm_pkg::INVALID_COORD, 1'b0, 1'b0};
        end else begin
            p.sx = ratio_q16(u, s, sat);
            p.sy = ratio_q16(v, s, sat);
            p.vr = 1'b1;
            p.sat = sat;
        end
        return p;
    endfunction

    // Receiver: random stalls, checks each returned transaction against the queue.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** homography_point_mapper: FAILED **");
            $finish;
        end else begin
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_points.size() == 0) begin
                    $error("unexpected result src_x=%h src_y=%h", o_src_x, o_src_y);
                    errors++;
                end else begin
                    t_point w;
                    w = pending_points.pop_front();
                    if (o_src_x !== w.sx) begin
                        $error("src_x: expected %h, got %h", w.sx, o_src_x);
                        errors++;
                    end
                    if (o_src_y !== w.sy) begin
                        $error("src_y: expected %h, got %h", w.sy, o_src_y);
                        errors++;
                    end
                    if (o_valid_res !== w.vr) begin
                        $error("valid_res: expected %b, got %b", w.vr, o_valid_res);
                        errors++;
                    end
                    if (o_saturated !== w.sat) begin
                        $error("saturated: expected %b, got %b", w.sat, o_saturated);
                        errors++;
                    end
                end
            end
            if (calm) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Hold a pixel until taken; expectation is either typed or predicted.
    task automatic send_point(logic [11:0] x, logic [11:0] y, bit typed, t_point want);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_dst_x <= x;
        i_dst_y <= y;
        do @(posedge i_clk); while (!o_ready);
        pending_points.push_back(typed ? want : project_point(x, y));
    endtask

    // Write one coefficient with the pipeline drained.
    task automatic write_coef(logic [hpm_pkg::IDX_W-1:0] idx, logic [63:0] data);
        i_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx < hpm_pkg::NREG) gain[idx] = data;
    endtask

    function automatic t_row cfg_row(logic [hpm_pkg::IDX_W-1:0] idx, logic [63:0] data);
        t_row r;
        r = '{ROW_CFG, idx, data, 12'd0, 12'd0, 1'b0, '{0, 0, 0, 0}};
        return r;
    endfunction

    function automatic t_row pt_row(logic [11:0] x, logic [11:0] y, bit typed,
                                    logic [31:0] sx, logic [31:0] sy, logic vr, logic sat);
        t_row r;
        r = '{ROW_POINT, '0, '0, x, y, typed, '{sx, sy, vr, sat}};
        return r;
    endfunction

    // Coefficient mix: extremes, raw bits, -2^-j, or modest gains, smaller in row 2.
    function automatic logic [63:0] pick_coef(int idx);
        logic [63:0] c;
        logic [31:0] r;
        int j;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: c = Q_MIN;
                    1: c = Q_MAX;
                    2: c = '0;
                    3: c = Q_ONE;
                    default: c = Q_M_ONE;
                endcase
            end
            1: c = {$urandom, $urandom};
            2: begin
                // make s vanish at a power-of-two coordinate
                j = $urandom_range(0, 11);
                c = $signed(Q_M_ONE) >>> j;
            end
            default: begin
                c = $signed({{32{r[31]}}, r}) <<< 3;
                if (idx >= hpm_pkg::REG_R2X) c = $signed(c) >>> 12;
            end
        endcase
        return c;
    endfunction

    initial begin
        logic [11:0] x, y;
        t_point none;
        none = '{0, 0, 0, 0};
        for (int k = 0; k < hpm_pkg::NREG; k++) gain[k] = '0;
        gain[hpm_pkg::REG_R0X] = Q_ONE;
        gain[hpm_pkg::REG_R1Y] = Q_ONE;

        // Identity after reset, extremes, zero and negative denominators, clipping.
        script.push_back(pt_row(12'd0, 12'd0, 1, 32'h0, 32'h0, 1, 0));
        script.push_back(pt_row(12'd4095, 12'd4095, 1, 32'h0FFF_0000, 32'h0FFF_0000, 1, 0));
        script.push_back(pt_row(12'd4095, 12'd0, 1, 32'h0FFF_0000, 32'h0, 1, 0));
        script.push_back(pt_row(12'd0, 12'd4095, 1, 32'h0, 32'h0FFF_0000, 1, 0));
        script.push_back(pt_row(12'hAAA, 12'h555, 0, 0, 0, 0, 0));
        script.push_back(cfg_row(hpm_pkg::REG_R2X, Q_M_ONE));
        script.push_back(pt_row(12'd1, 12'd7, 1, hpm_pkg::INVALID_COORD,
                                hpm_pkg::INVALID_COORD, 0, 0));
        script.push_back(pt_row(12'd0, 12'd7, 0, 0, 0, 0, 0));
        script.push_back(pt_row(12'd2, 12'd9, 0, 0, 0, 0, 0));
        script.push_back(cfg_row(hpm_pkg::REG_R2X, '0));
        script.push_back(cfg_row(hpm_pkg::REG_R0X, Q_MAX));
        script.push_back(pt_row(12'd4095, 12'd0, 1, 32'h7FFF_FFFF, 32'h0, 1, 1));
        script.push_back(cfg_row(hpm_pkg::REG_R1Y, Q_MIN));
        script.push_back(pt_row(12'd0, 12'd4095, 1, 32'h0, 32'h8000_0000, 1, 1));
        script.push_back(cfg_row(hpm_pkg::REG_R0Y, 64'h0000_0000_8000_0000));
        script.push_back(cfg_row(hpm_pkg::REG_R0O, 64'hFFFF_FFFF_FFFF_8000));
        script.push_back(cfg_row(hpm_pkg::REG_R1X, 64'h0000_0000_0000_0001));
        script.push_back(cfg_row(hpm_pkg::REG_R1O, 64'h0000_0003_4000_0000));
        script.push_back(cfg_row(hpm_pkg::REG_R2Y, 64'h0000_0000_0010_0000));
        script.push_back(cfg_row(IDX_UNUSED, Q_MAX));
        script.push_back(pt_row(12'd1, 12'd1, 0, 0, 0, 0, 0));
        script.push_back(pt_row(12'd4095, 12'd4095, 0, 0, 0, 0, 0));
        script.push_back(pt_row(12'd37, 12'd2048, 0, 0, 0, 0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table.
        foreach (script[k]) begin
            if (script[k].kind == ROW_CFG) write_coef(script[k].idx, script[k].data);
            else send_point(script[k].x, script[k].y, script[k].typed, script[k].want);
        end

        // Random matrices; every phase rewrites all registers.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int k = 0; k < hpm_pkg::NREG; k++) begin
                write_coef(hpm_pkg::t_reg_idx'(k), pick_coef(k));
            end
            if ($urandom_range(0, 2) == 0) write_coef(IDX_UNUSED, {$urandom, $urandom});
            calm = (ph == RAND_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    x = 12'd1 << $urandom_range(0, 11);
                    y = 12'd1 << $urandom_range(0, 11);
                    if ($urandom_range(0, 1) == 0) y = '0;
                end else begin
                    x = 12'($urandom_range(0, 4095));
                    y = 12'($urandom_range(0, 4095));
                end
                send_point(x, y, 0, none);
            end
        end

        i_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("** homography_point_mapper: PASSED **");
        end else begin
            $display("** homography_point_mapper: FAILED **");
        end
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/hpm_pkg.sv
hw/rtl/hpm_div_cell.sv
hw/rtl/hpm_front.sv
hw/rtl/hpm_round.sv
hw/rtl/homography_point_mapper.sv
tb/sv/testbench.sv
